// ----- src/wbps_pkg.sv -----
// wbps_pkg: shared types and constants of the wildcard byte pattern search core
// used by the channel interfaces, the register block, the scan stage and the top level
`default_nettype none

package wbps_pkg;

  // fixed widths of the register file and the channel fields
  localparam int PATTERN_SLOTS = 16;
  localparam int LEN_W         = 5;
  localparam int BYTE_W        = 8;
  localparam int ADDR_OUT_W    = 32;
  localparam int COUNT_W       = 32;
  localparam int CFG_INDEX_W   = 3;
  localparam int CFG_DATA_W    = 64;
  localparam int MASK_W        = 16;

  // register indexes of the configuration channel
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PATTERN_LOW  = 3'd0,
    REG_PATTERN_HIGH = 3'd1,
    REG_WILDCARD     = 3'd2,
    REG_LENGTH       = 3'd3,
    REG_BASE         = 3'd4
  } cfg_index_t;

  // pattern as seen by the scan stage: slot j lines up with the byte j steps back
  typedef struct packed {
    logic [PATTERN_SLOTS-1:0][BYTE_W-1:0] pattern;
    logic [PATTERN_SLOTS-1:0]             care;
    logic [LEN_W-1:0]                     length;
    logic [ADDR_OUT_W-1:0]                base;
  } scan_cfg_t;

endpackage

`default_nettype wire

// ----- src/wbps_byte_if.sv -----
// wbps_byte_if: request channel that carries one scanned byte and its end-of-range mark
// depends on wbps_pkg for field widths
`default_nettype none

interface wbps_byte_if;
  import wbps_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              last;

  modport source (output valid, output data_byte, output last, input ready);
  modport sink   (input valid, input data_byte, input last, output ready);
endinterface

`default_nettype wire

// ----- src/wbps_result_if.sv -----
// wbps_result_if: request channel that carries one search result
// depends on wbps_pkg for field widths
`default_nettype none

interface wbps_result_if;
  import wbps_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  found;
  logic [ADDR_OUT_W-1:0] match_address;

  modport source (output valid, output found, output match_address, input ready);
  modport sink   (input valid, input found, input match_address, output ready);
endinterface

`default_nettype wire

// ----- src/wbps_cfg_if.sv -----
// wbps_cfg_if: register write channel, one register index and its write data per request
// depends on wbps_pkg for field widths
`default_nettype none

interface wbps_cfg_if;
  import wbps_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] reg_index;
  logic [CFG_DATA_W-1:0]  write_data;

  modport source (output valid, output reg_index, output write_data, input ready);
  modport sink   (input valid, input reg_index, input write_data, output ready);
endinterface

`default_nettype wire

// ----- src/wbps_cfg_regs.sv -----
// wbps_cfg_regs: configuration registers and the realigned pattern for the scan stage
// depends on wbps_pkg and wbps_cfg_if
`default_nettype none

module wbps_cfg_regs #(
  parameter int MAX_PATTERN_BYTES = 16
) (
  input  wire                 clk,
  input  wire                 rst,
  wbps_cfg_if.sink            cfg,
  output wbps_pkg::scan_cfg_t scan_cfg
);
  import wbps_pkg::*;

  logic [CFG_DATA_W-1:0] pattern_low;
  logic [CFG_DATA_W-1:0] pattern_high;
  logic [MASK_W-1:0]     wildcard_mask;
  logic [LEN_W-1:0]      pattern_length;
  logic [ADDR_OUT_W-1:0] base_address;

  logic [PATTERN_SLOTS-1:0][BYTE_W-1:0] pattern_bytes;
  logic [LEN_W-1:0]                     eff_length;
  logic [LEN_W-1:0]                     src_pos;
  scan_cfg_t                            scan_cfg_next;

  assign cfg.ready = 1'b1;

  // register writes, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low    <= '0;
      pattern_high   <= '0;
      wildcard_mask  <= '0;
      pattern_length <= LEN_W'(1);
      base_address   <= '0;
    end else if (cfg.valid) begin
      case (cfg.reg_index)
        REG_PATTERN_LOW:  pattern_low    <= cfg.write_data;
        REG_PATTERN_HIGH: pattern_high   <= cfg.write_data;
        REG_WILDCARD:     wildcard_mask  <= cfg.write_data[MASK_W-1:0];
        REG_LENGTH:       pattern_length <= cfg.write_data[LEN_W-1:0];
        REG_BASE:         base_address   <= cfg.write_data[ADDR_OUT_W-1:0];
        default: ;
      endcase
    end
  end

  assign pattern_bytes = {pattern_high, pattern_low};

  // zero counts as one, anything above the maximum saturates
  always_comb begin
    if (pattern_length == '0) begin
      eff_length = LEN_W'(1);
    end else if (pattern_length > LEN_W'(MAX_PATTERN_BYTES)) begin
      eff_length = LEN_W'(MAX_PATTERN_BYTES);
    end else begin
      eff_length = pattern_length;
    end
  end

  // slot j holds pattern byte length-1-j, so slot 0 meets the newest byte
  always_comb begin
    src_pos               = '0;
    scan_cfg_next.pattern = '0;
    scan_cfg_next.care    = '0;
    scan_cfg_next.length  = eff_length;
    scan_cfg_next.base    = base_address;
    for (int j = 0; j < PATTERN_SLOTS; j++) begin
      if (LEN_W'(j) < eff_length) begin
        src_pos                  = eff_length - LEN_W'(j) - LEN_W'(1);
        scan_cfg_next.pattern[j] = pattern_bytes[src_pos[3:0]];
        scan_cfg_next.care[j]    = ~wildcard_mask[src_pos[3:0]];
      end
    end
  end

  // registered copy of the realigned pattern, length and base
  always_ff @(posedge clk) begin
    scan_cfg <= scan_cfg_next;
  end

endmodule

`default_nettype wire

// ----- src/wbps_scan.sv -----
// wbps_scan: input register, byte window, match compare and result register
// depends on wbps_pkg, wbps_byte_if and wbps_result_if
`default_nettype none

module wbps_scan #(
  parameter int MAX_PATTERN_BYTES = 16,
  parameter int ADDRESS_BITS      = 32
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wbps_pkg::scan_cfg_t scan_cfg,
  wbps_byte_if.sink           byte_in,
  wbps_result_if.source       result_out
);
  import wbps_pkg::*;

  localparam int WIN_DEPTH = (MAX_PATTERN_BYTES > 1) ? MAX_PATTERN_BYTES - 1 : 1;

  // input register
  logic              s1_valid;
  logic [BYTE_W-1:0] s1_byte;
  logic              s1_last;

  // scan state
  logic [WIN_DEPTH-1:0][BYTE_W-1:0] window;
  logic [COUNT_W-1:0]               bytes_seen;
  logic                             scan_done;

  // result register
  logic                  out_valid;
  logic                  out_found;
  logic [ADDR_OUT_W-1:0] out_address;

  logic                         out_free;
  logic                         fire;
  logic [MAX_PATTERN_BYTES-1:0] slot_ok;
  logic                         enough;
  logic                         hit;
  logic [COUNT_W-1:0]           offset;
  logic [ADDRESS_BITS-1:0]      addr_sum;

  assign out_free      = ~out_valid | result_out.ready;
  assign fire          = s1_valid & out_free;
  assign byte_in.ready = ~s1_valid | out_free;

  // input register takes a new byte whenever the stage moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (byte_in.ready) begin
      s1_valid <= byte_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_in.ready) begin
      s1_byte <= byte_in.data_byte;
      s1_last <= byte_in.last;
    end
  end

  // per-slot compare, slot 0 is the current byte
  always_comb begin
    for (int j = 0; j < MAX_PATTERN_BYTES; j++) begin
      if (j == 0) begin
        slot_ok[j] = ~scan_cfg.care[j] | (s1_byte == scan_cfg.pattern[j]);
      end else begin
        slot_ok[j] = ~scan_cfg.care[j] | (window[j-1] == scan_cfg.pattern[j]);
      end
    end
  end

  assign enough = bytes_seen >= COUNT_W'(scan_cfg.length - LEN_W'(1));
  assign hit    = ~scan_done & enough & (&slot_ok);

  // start address of the match, wrapped to the address width
  assign offset   = bytes_seen + COUNT_W'(1) - COUNT_W'(scan_cfg.length);
  assign addr_sum = ADDRESS_BITS'(scan_cfg.base) + ADDRESS_BITS'(offset);

  // window, count and done flag
  always_ff @(posedge clk) begin
    if (rst) begin
      window     <= '0;
      bytes_seen <= '0;
      scan_done  <= 1'b0;
    end else if (fire) begin
      if (s1_last) begin
        window     <= '0;
        bytes_seen <= '0;
        scan_done  <= 1'b0;
      end else if (!scan_done) begin
        if (hit) begin
          scan_done <= 1'b1;
        end else begin
          window[0] <= s1_byte;
          for (int k = 1; k < WIN_DEPTH; k++) begin
            window[k] <= window[k-1];
          end
          if (bytes_seen != '1) begin
            bytes_seen <= bytes_seen + COUNT_W'(1);
          end
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && !scan_done && (hit || s1_last)) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && !scan_done) begin
      out_found   <= hit;
      out_address <= hit ? ADDR_OUT_W'(addr_sum) : '0;
    end
  end

  assign result_out.valid         = out_valid;
  assign result_out.found         = out_found;
  assign result_out.match_address = out_address;

`ifndef SYNTHESIS
  // a not-found result never carries an address
  a_notfound_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_found |-> out_address == '0)
    else $error("not-found result with nonzero address");

  // the end of a range always restarts the scan
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    fire && s1_last |=> bytes_seen == '0 && !scan_done)
    else $error("scan state not cleared after last byte");

  // the done flag is only set together with a found result
  a_done_with_found: assert property (@(posedge clk) disable iff (rst)
    $rose(scan_done) |-> out_valid && out_found)
    else $error("done flag set without a found result");

  // a held byte is not dropped from the input register
  a_s1_held: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !fire |=> s1_valid && $stable(s1_byte) && $stable(s1_last))
    else $error("stalled byte lost from input register");
`endif

endmodule

`default_nettype wire

// ----- src/wildcard_byte_pattern_search_core.sv -----
// wildcard_byte_pattern_search_core: top level of the wildcard byte signature scanner
// depends on wbps_pkg, the three channel interfaces, wbps_cfg_regs and wbps_scan
//
// Usage:
//   byte_in    carries one memory byte per request, last marks the final byte of a range.
//   result_out carries at most one result per range: found = 1 with the start address of
//              the first match, or found = 0 with address zero when the range ends unmatched.
//              Bytes after a match are dropped until the last byte of the range.
//   cfg        writes pattern bytes, wildcard mask, length and base address by index;
//              it is always ready and should be written only while no scan is in flight.
// Timing:
//   one byte per cycle sustained while result_out takes results; the byte that causes a
//   result lands in the input register, then the compare loads the result register.
//   The window of previous bytes sits beside the compare, so every byte sees the full
//   pattern at once.
// Reset (rst, synchronous): clears the window, the byte count, the done flag and both
//   pipeline registers; registers take their reset values (length one, all else zero).
// Stall: when result_out is held, the result register keeps its value, the input
//   register holds one more byte and byte_in.ready drops until the result is taken.
`default_nettype none

module wildcard_byte_pattern_search_core #(
  parameter int MAX_PATTERN_BYTES = 16,
  parameter int ADDRESS_BITS      = 32
) (
  input  wire           clk,
  input  wire           rst,
  wbps_byte_if.sink     byte_in,
  wbps_result_if.source result_out,
  wbps_cfg_if.sink      cfg
);
  import wbps_pkg::*;

  scan_cfg_t scan_cfg;

  // configuration and pattern alignment
  wbps_cfg_regs #(
    .MAX_PATTERN_BYTES(MAX_PATTERN_BYTES)
  ) u_cfg_regs (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .scan_cfg (scan_cfg)
  );

  // byte window and match compare
  wbps_scan #(
    .MAX_PATTERN_BYTES(MAX_PATTERN_BYTES),
    .ADDRESS_BITS     (ADDRESS_BITS)
  ) u_scan (
    .clk        (clk),
    .rst        (rst),
    .scan_cfg   (scan_cfg),
    .byte_in    (byte_in),
    .result_out (result_out)
  );

endmodule

`default_nettype wire
